### hdl/dnms_pkg.sv
// -----------------------------------------------------------------------------
// dnms_pkg
// Types and constants shared by the per-class NMS block and its submodules.
// -----------------------------------------------------------------------------
package dnms_pkg;

   localparam int ROW_HEAD    = 5;
   localparam int BOX_FIELDS  = 4;
   localparam int MAX_CLASSES = 128;
   localparam int ONE_Q16     = 65536;
   // Cycles from the last suppression read until its alive bit is settled.
   localparam int SUP_DRAIN   = 6;

   localparam logic [3:0] REG_NUM_CLASSES = 4'd0;
   localparam logic [3:0] REG_SCORE_THR   = 4'd1;
   localparam logic [3:0] REG_IOU_THR     = 4'd2;
   localparam logic [3:0] REG_TOP_K       = 4'd3;

   localparam logic [7:0]  NUM_CLASSES_RST = 8'd80;
   localparam logic [16:0] SCORE_THR_RST   = 17'd16384;
   localparam logic [16:0] IOU_THR_RST     = 17'd29491;
   localparam logic [6:0]  TOP_K_RST       = 7'd64;

   typedef struct packed {
      logic signed [31:0] left;
      logic signed [31:0] top;
      logic signed [31:0] right;
      logic signed [31:0] bottom;
      logic [16:0]        score;
      logic [6:0]         cls;
   } cand_type;

   typedef struct packed {
      logic alive_init;
      logic sel_clear;
      logic rd_en;
      logic rd_sup;
      logic pick;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic sel_found;
      logic pend_v;
      logic out_v;
   } sts_type;

endpackage

### hdl/dnms_ifs.sv
// -----------------------------------------------------------------------------
// dnms channel interfaces
// Input value stream, result stream and register write channel.
// -----------------------------------------------------------------------------
interface dnms_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               frame_last;
   modport source (output valid, value, frame_last, input ready);
   modport sink (input valid, value, frame_last, output ready);
endinterface

interface dnms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left;
   logic signed [31:0] top;
   logic signed [31:0] right;
   logic signed [31:0] bottom;
   logic [16:0]        score;
   logic [6:0]         cls_idx;
   logic               empty_res;
   logic               last;
   modport source (output valid, left, top, right, bottom, score, cls_idx, empty_res,
                   last, input ready);
   modport sink (input valid, left, top, right, bottom, score, cls_idx, empty_res,
                 last, output ready);
endinterface

interface dnms_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [16:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/dnms_ram.sv
// -----------------------------------------------------------------------------
// dnms_ram
// Simple dual-port RAM, one write port and one registered read port.
// -----------------------------------------------------------------------------
module dnms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/dnms_ctrl.sv
// -----------------------------------------------------------------------------
// dnms_ctrl
// Sequencer: row intake, frame-end drain, selection and suppression scans.
// -----------------------------------------------------------------------------
module dnms_ctrl #(
   parameter int CW = 7,
   parameter int AW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_frame_last,
   output logic              req_ready,
   input  dnms_pkg::sts_type sts,
   input  logic [CW-1:0]     cnt,
   output dnms_pkg::cmd_type cmd,
   output logic [AW-1:0]     rd_addr
);

   typedef enum logic [2:0] {ST_IDLE, ST_DRAIN, ST_SEL, ST_DECIDE, ST_SUP} state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [2:0]  wait_ff, wait_in;
   logic        scan_more;

   assign scan_more = scan_ff < cnt;
   assign rd_addr   = scan_ff[AW-1:0];
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_frame_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last row may still be on its way into the candidate store.
            if (!sts.busy) begin
               cmd.alive_init = 1'b1;
               cmd.sel_clear  = 1'b1;
               scan_in        = '0;
               state_in       = ST_SEL;
            end
         end
         ST_SEL: begin
            if (scan_more) begin
               cmd.rd_en = 1'b1;
               scan_in   = scan_ff + 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.sel_found) begin
               if (!(sts.pend_v && sts.out_v)) begin
                  cmd.pick = 1'b1;
                  scan_in  = '0;
                  wait_in  = '0;
                  state_in = ST_SUP;
               end
            end else if (!sts.out_v) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SUP: begin
            if (scan_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sup = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end else if (wait_ff == 3'(dnms_pkg::SUP_DRAIN)) begin
               cmd.sel_clear = 1'b1;
               scan_in       = '0;
               state_in      = ST_SEL;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

### hdl/dnms_dp.sv
// -----------------------------------------------------------------------------
// dnms_dp
// Datapath: registers, row decode, candidate store, IoU pipeline and result.
// -----------------------------------------------------------------------------
module dnms_dp #(
   parameter int MAX_CANDIDATES = 64,
   parameter int CW = 7,
   parameter int AW = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic signed [31:0] in_value,
   input  logic               in_frame_last,
   input  logic               csr_we,
   input  logic [3:0]         csr_index,
   input  logic [16:0]        csr_data,
   input  dnms_pkg::cmd_type  cmd,
   input  logic [AW-1:0]      rd_addr,
   output dnms_pkg::sts_type  sts,
   output logic [CW-1:0]      cnt,
   output logic               out_v,
   input  logic               out_take,
   output dnms_pkg::cand_type out_cand,
   output logic               out_empty,
   output logic               out_last
);

   localparam int CMPW = (CW > 7) ? CW : 7;
   localparam int WIDTH = $bits(dnms_pkg::cand_type);

   function automatic logic signed [31:0] edge_calc(input logic signed [31:0] c,
                                                    input logic signed [31:0] w,
                                                    input logic add);
      logic signed [33:0] t;
      logic signed [33:0] h;
      begin
         t = add ? (34'(c) * 34'sd2 + 34'(w)) : (34'(c) * 34'sd2 - 34'(w));
         h = t >>> 1;
         if (h > 34'sh0_7FFF_FFFF) begin
            edge_calc = 32'sh7FFF_FFFF;
         end else if (h < -34'sh0_8000_0000) begin
            edge_calc = 32'sh8000_0000;
         end else begin
            edge_calc = h[31:0];
         end
      end
   endfunction

   // Configuration registers.
   logic [7:0]  ncls_ff;
   logic [16:0] sthr_ff, ithr_ff;
   logic [6:0]  topk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncls_ff <= dnms_pkg::NUM_CLASSES_RST;
         sthr_ff <= dnms_pkg::SCORE_THR_RST;
         ithr_ff <= dnms_pkg::IOU_THR_RST;
         topk_ff <= dnms_pkg::TOP_K_RST;
      end else if (csr_we) begin
         case (csr_index)
            dnms_pkg::REG_NUM_CLASSES: ncls_ff <= csr_data[7:0];
            dnms_pkg::REG_SCORE_THR:   sthr_ff <= csr_data;
            dnms_pkg::REG_IOU_THR:     ithr_ff <= csr_data;
            dnms_pkg::REG_TOP_K:       topk_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Row decode.
   logic [8:0]         pos_ff;
   logic signed [31:0] box_ff [dnms_pkg::BOX_FIELDS];
   logic signed [31:0] obj_ff, best_ff, best_in;
   logic [6:0]         bidx_ff, bidx_in;
   logic [8:0]         eff_cls;
   logic               row_end;

   assign eff_cls = (ncls_ff == 8'd0) ? 9'd1 :
                    (ncls_ff > 8'(dnms_pkg::MAX_CLASSES)) ? 9'(dnms_pkg::MAX_CLASSES) :
                    9'(ncls_ff);
   assign row_end = pos_ff >= (eff_cls + 9'(dnms_pkg::BOX_FIELDS));

   always_comb begin
      best_in = best_ff;
      bidx_in = bidx_ff;
      if (pos_ff > 9'(dnms_pkg::BOX_FIELDS) && in_value > best_ff) begin
         best_in = in_value;
         bidx_in = 7'(pos_ff - 9'(dnms_pkg::ROW_HEAD));
      end
   end

   logic               f1_v_ff;
   logic signed [31:0] f1_box_ff [dnms_pkg::BOX_FIELDS];
   logic signed [31:0] f1_obj_ff, f1_best_ff;
   logic [6:0]         f1_cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         obj_ff  <= '0;
         best_ff <= '0;
         bidx_ff <= '0;
         f1_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= take && row_end;
         if (take) begin
            if (pos_ff < 9'(dnms_pkg::BOX_FIELDS)) begin
               box_ff[pos_ff[1:0]] <= in_value;
            end else if (pos_ff == 9'(dnms_pkg::BOX_FIELDS)) begin
               obj_ff <= in_value;
            end
            if (row_end || in_frame_last) begin
               pos_ff  <= '0;
               best_ff <= '0;
               bidx_ff <= '0;
            end else begin
               pos_ff  <= pos_ff + 1'b1;
               best_ff <= best_in;
               bidx_ff <= bidx_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && row_end) begin
         f1_box_ff  <= box_ff;
         f1_obj_ff  <= obj_ff;
         f1_best_ff <= best_in;
         f1_cls_ff  <= bidx_in;
      end
   end

   // Score product and corner boxes.
   logic               f2_v_ff, f2_pass_ff;
   logic signed [63:0] f2_prod_ff;
   dnms_pkg::cand_type f2_cand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else begin
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      f2_pass_ff        <= 33'(f1_obj_ff) >= $signed({16'd0, sthr_ff});
      f2_prod_ff        <= 64'(f1_obj_ff) * 64'(f1_best_ff);
      f2_cand_ff.left   <= edge_calc(f1_box_ff[0], f1_box_ff[2], 1'b0);
      f2_cand_ff.top    <= edge_calc(f1_box_ff[1], f1_box_ff[3], 1'b0);
      f2_cand_ff.right  <= edge_calc(f1_box_ff[0], f1_box_ff[2], 1'b1);
      f2_cand_ff.bottom <= edge_calc(f1_box_ff[1], f1_box_ff[3], 1'b1);
      f2_cand_ff.score  <= '0;
      f2_cand_ff.cls    <= f1_cls_ff;
   end

   logic signed [47:0] prod_q;
   logic               keep;
   logic [CW-1:0]      cnt_ff;
   dnms_pkg::cand_type wr_cand;

   assign prod_q = f2_prod_ff[63:16];
   assign keep   = f2_v_ff && f2_pass_ff && (prod_q >= $signed({31'd0, sthr_ff})) &&
                   (CMPW'(cnt_ff) < CMPW'(topk_ff)) &&
                   (CMPW'(cnt_ff) < CMPW'(MAX_CANDIDATES));

   always_comb begin
      wr_cand       = f2_cand_ff;
      wr_cand.score = (prod_q > 48'sd65536) ? 17'(dnms_pkg::ONE_Q16) : prod_q[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.finish) begin
         cnt_ff <= '0;
      end else if (keep) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign cnt = cnt_ff;

   // Candidate store.
   logic [WIDTH-1:0]   rdata;
   dnms_pkg::cand_type q;

   dnms_ram #(.WIDTH(WIDTH), .DEPTH(MAX_CANDIDATES), .AW(AW)) u_store (
      .clock (clock),
      .we    (keep),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (wr_cand),
      .re    (cmd.rd_en),
      .raddr (rd_addr),
      .rdata (rdata)
   );

   assign q = dnms_pkg::cand_type'(rdata);

   logic          rd_v_ff, rd_sup_ff;
   logic [AW-1:0] rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_en;
      end
      rd_sup_ff <= cmd.rd_sup;
      rd_idx_ff <= rd_addr;
   end

   // Selection: lowest class, then highest score, first index on ties.
   logic [MAX_CANDIDATES-1:0] alive_ff;
   logic               sel_found_ff;
   dnms_pkg::cand_type sel_ff, pend_ff;
   logic [AW-1:0]      sel_idx_ff;
   logic               pend_v_ff;
   logic               sel_hit;

   assign sel_hit = rd_v_ff && !rd_sup_ff && alive_ff[rd_idx_ff] &&
                    (!sel_found_ff || q.cls < sel_ff.cls ||
                     (q.cls == sel_ff.cls && q.score > sel_ff.score));

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_found_ff <= 1'b0;
      end else if (cmd.sel_clear) begin
         sel_found_ff <= 1'b0;
      end else if (sel_hit) begin
         sel_found_ff <= 1'b1;
      end
      if (sel_hit) begin
         sel_ff     <= q;
         sel_idx_ff <= rd_idx_ff;
      end
   end

   // Suppression pipeline against the held pick.
   logic               s1_v_ff;
   logic [AW-1:0]      s1_idx_ff;
   logic signed [31:0] s1_il_ff, s1_it_ff, s1_ir_ff, s1_ib_ff;
   logic signed [32:0] s1_pw_ff, s1_ph_ff, s1_qw_ff, s1_qh_ff;

   logic               s2_v_ff, s2_disj_ff;
   logic [AW-1:0]      s2_idx_ff;
   logic signed [65:0] s2_inter_ff, s2_pa_ff, s2_qa_ff;

   logic               s3_v_ff, s3_disj_ff;
   logic [AW-1:0]      s3_idx_ff;
   logic signed [65:0] s3_inter_ff;
   logic signed [67:0] s3_uni_ff;

   logic               s4_v_ff, s4_disj_ff, s4_upos_ff, s4_uzero_ff, s4_izero_ff;
   logic [AW-1:0]      s4_idx_ff;
   logic signed [85:0] s4_lhs_ff, s4_rhs_ff;

   logic signed [32:0] iw, ih;
   logic               thr_zero, supp;

   assign iw = 33'(s1_ir_ff) - 33'(s1_il_ff);
   assign ih = 33'(s1_ib_ff) - 33'(s1_it_ff);
   assign thr_zero = (ithr_ff == 17'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= rd_v_ff && rd_sup_ff && alive_ff[rd_idx_ff] && (q.cls == pend_ff.cls);
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_idx_ff;
      s1_il_ff  <= (pend_ff.left > q.left) ? pend_ff.left : q.left;
      s1_it_ff  <= (pend_ff.top > q.top) ? pend_ff.top : q.top;
      s1_ir_ff  <= (pend_ff.right < q.right) ? pend_ff.right : q.right;
      s1_ib_ff  <= (pend_ff.bottom < q.bottom) ? pend_ff.bottom : q.bottom;
      s1_pw_ff  <= 33'(pend_ff.right) - 33'(pend_ff.left);
      s1_ph_ff  <= 33'(pend_ff.bottom) - 33'(pend_ff.top);
      s1_qw_ff  <= 33'(q.right) - 33'(q.left);
      s1_qh_ff  <= 33'(q.bottom) - 33'(q.top);

      s2_idx_ff   <= s1_idx_ff;
      s2_disj_ff  <= (s1_il_ff > s1_ir_ff) || (s1_it_ff > s1_ib_ff);
      s2_inter_ff <= 66'(iw) * 66'(ih);
      s2_pa_ff    <= 66'(s1_pw_ff) * 66'(s1_ph_ff);
      s2_qa_ff    <= 66'(s1_qw_ff) * 66'(s1_qh_ff);

      s3_idx_ff   <= s2_idx_ff;
      s3_disj_ff  <= s2_disj_ff;
      s3_inter_ff <= s2_inter_ff;
      s3_uni_ff   <= 68'(s2_pa_ff) + 68'(s2_qa_ff) - 68'(s2_inter_ff);

      s4_idx_ff   <= s3_idx_ff;
      s4_disj_ff  <= s3_disj_ff;
      s4_upos_ff  <= s3_uni_ff > 68'sd0;
      s4_uzero_ff <= s3_uni_ff == 68'sd0;
      s4_izero_ff <= s3_inter_ff == 66'sd0;
      s4_lhs_ff   <= 86'(s3_inter_ff) <<< 16;
      s4_rhs_ff   <= 86'(s3_uni_ff) * 86'($signed({1'b0, ithr_ff}));
   end

   always_comb begin
      if (s4_disj_ff) begin
         supp = thr_zero;
      end else if (s4_uzero_ff) begin
         supp = 1'b0;
      end else if (!s4_upos_ff) begin
         supp = s4_izero_ff && thr_zero;
      end else begin
         supp = s4_lhs_ff >= s4_rhs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '0;
      end else if (cmd.alive_init) begin
         alive_ff <= '1;
      end else begin
         if (cmd.pick) begin
            alive_ff[sel_idx_ff] <= 1'b0;
         end
         if (s4_v_ff && supp) begin
            alive_ff[s4_idx_ff] <= 1'b0;
         end
      end
   end

   // A pick is held until the next selection shows whether it is the last.
   logic               out_v_ff, out_empty_ff, out_last_ff;
   dnms_pkg::cand_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (out_take) begin
            out_v_ff <= 1'b0;
         end
         if (cmd.pick) begin
            pend_v_ff <= 1'b1;
            if (pend_v_ff) begin
               out_v_ff <= 1'b1;
            end
         end else if (cmd.finish) begin
            pend_v_ff <= 1'b0;
            out_v_ff  <= 1'b1;
         end
      end
   end

   // The first pick of a frame leaves the output alone, since a result of the
   // previous frame may still be waiting there.
   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         pend_ff <= sel_ff;
         if (pend_v_ff) begin
            out_ff       <= pend_ff;
            out_empty_ff <= 1'b0;
            out_last_ff  <= 1'b0;
         end
      end else if (cmd.finish) begin
         out_ff       <= pend_v_ff ? pend_ff : '0;
         out_empty_ff <= !pend_v_ff;
         out_last_ff  <= 1'b1;
      end
   end

   assign out_v     = out_v_ff;
   assign out_cand  = out_ff;
   assign out_empty = out_empty_ff;
   assign out_last  = out_last_ff;

   assign sts.busy      = f1_v_ff || f2_v_ff;
   assign sts.sel_found = sel_found_ff;
   assign sts.pend_v    = pend_v_ff;
   assign sts.out_v     = out_v_ff;

endmodule

### hdl/detection_decode_class_nms_top.sv
// Takes one row value per cycle while collecting a frame; the last row passes the f1
// and f2 registers before it is written into the candidate store. At frame end input
// stalls for suppression: per emitted box one selection scan and one IoU scan over
// the N stored candidates, each scan one candidate read a cycle.
// Synchronous active-high reset restores the register defaults and clears the
// row state, candidate count and alive bits; the candidate store is not cleared.
// -----------------------------------------------------------------------------
// detection_decode_class_nms_top
// Row decode, score filtering and per-class non-maximum suppression.
// -----------------------------------------------------------------------------
module detection_decode_class_nms_top #(
   parameter int MAX_CANDIDATES = 64
) (
   input  logic       clock,
   input  logic       reset,
   dnms_req_if.sink   req_ch,
   dnms_rsp_if.source rsp_ch,
   dnms_csr_if.sink   csr_ch
);

   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

   dnms_pkg::cmd_type  cmd;
   dnms_pkg::sts_type  sts;
   dnms_pkg::cand_type out_cand;
   logic [CW-1:0]      cnt;
   logic [AW-1:0]      rd_addr;
   logic               req_ready;
   logic               out_v;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   dnms_ctrl #(.CW(CW), .AW(AW)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_frame_last (req_ch.frame_last),
      .req_ready      (req_ready),
      .sts            (sts),
      .cnt            (cnt),
      .cmd            (cmd),
      .rd_addr        (rd_addr)
   );

   dnms_dp #(.MAX_CANDIDATES(MAX_CANDIDATES), .CW(CW), .AW(AW)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .take          (req_ch.valid && req_ready),
      .in_value      (req_ch.value),
      .in_frame_last (req_ch.frame_last),
      .csr_we        (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .sts           (sts),
      .cnt           (cnt),
      .out_v         (out_v),
      .out_take      (out_v && rsp_ch.ready),
      .out_cand      (out_cand),
      .out_empty     (rsp_ch.empty_res),
      .out_last      (rsp_ch.last)
   );

   assign rsp_ch.valid   = out_v;
   assign rsp_ch.left    = out_cand.left;
   assign rsp_ch.top     = out_cand.top;
   assign rsp_ch.right   = out_cand.right;
   assign rsp_ch.bottom  = out_cand.bottom;
   assign rsp_ch.score   = out_cand.score;
   assign rsp_ch.cls_idx = out_cand.cls;

endmodule

### dv/detection_decode_class_nms_top_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// detection_decode_class_nms_top_test
// Streams detector rows into the per-class NMS block under random handshake
// gaps and checks every emitted box against an in-bench prediction of the
// row filter, candidate store and per-class suppression pass.
// -----------------------------------------------------------------------------
module detection_decode_class_nms_top_test;

   localparam int CAND_MAX    = 64;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int ITEM_GOAL   = 380;

   typedef struct packed {
      logic signed [31:0] left;
      logic signed [31:0] top;
      logic signed [31:0] right;
      logic signed [31:0] bottom;
      logic [16:0]        score;
      logic [6:0]         cls;
      logic               empty_res;
      logic               last;
   } det_type;

   typedef struct {
      int  value;
      bit  frame_last;
      bit  typed;
      det_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   dnms_req_if req_ch ();
   dnms_rsp_if rsp_ch ();
   dnms_csr_if csr_ch ();

   detection_decode_class_nms_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Shadow of the block's registers, row decoder and candidate store.
   int unsigned cfg_classes, cfg_score_thr, cfg_iou_thr, cfg_top_k;
   int unsigned row_pos;
   int          row_box[4];
   int          row_obj;
   int          best_score;
   int unsigned best_idx;
   int unsigned cand_n;
   int          cand_box[CAND_MAX][4];
   int unsigned cand_score[CAND_MAX];
   int unsigned cand_cls[CAND_MAX];
   bit          cand_live[CAND_MAX];

   det_type expected_dets[$];
   int      errors;
   int      items_sent;
   int      cycles;
   bit      req_burst;
   bit      rsp_burst;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic string det_text(input det_type d);
      return $sformatf("l=%0d t=%0d r=%0d b=%0d s=%0d c=%0d e=%b last=%b",
                       d.left, d.top, d.right, d.bottom, d.score, d.cls,
                       d.empty_res, d.last);
   endfunction

   function automatic int unsigned live_classes();
      if (cfg_classes == 0) return 1;
      return (cfg_classes > dnms_pkg::MAX_CLASSES) ? dnms_pkg::MAX_CLASSES : cfg_classes;
   endfunction

   function automatic int corner_edge(input longint twice);
      longint half;
      half = twice >>> 1;
      if (half > 64'sd2147483647) return 32'h7fffffff;
      if (half < -64'sd2147483648) return 32'h80000000;
      return int'(half);
   endfunction

   function automatic void clear_row();
      row_pos = 0;
      row_box = '{0, 0, 0, 0};
      row_obj = 0;
      best_score = 0;
      best_idx = 0;
   endfunction

   function automatic void keep_row();
      longint thr;
      longint prod;
      longint cx, cy, w, h;
      int unsigned cap;
      thr = longint'(cfg_score_thr);
      cap = (cfg_top_k > CAND_MAX) ? CAND_MAX : cfg_top_k;
      if (longint'(row_obj) < thr) return;
      prod = (longint'(row_obj) * longint'(best_score)) / 65536;
      if (prod < thr) return;
      if (cand_n >= cap) return;
      cx = row_box[0];
      cy = row_box[1];
      w  = row_box[2];
      h  = row_box[3];
      cand_box[cand_n][0] = corner_edge(2 * cx - w);
      cand_box[cand_n][1] = corner_edge(2 * cy - h);
      cand_box[cand_n][2] = corner_edge(2 * cx + w);
      cand_box[cand_n][3] = corner_edge(2 * cy + h);
      cand_score[cand_n] = (prod > dnms_pkg::ONE_Q16) ? dnms_pkg::ONE_Q16 : int'(prod);
      cand_cls[cand_n] = best_idx;
      cand_n++;
   endfunction

   // True when box a, already emitted, knocks out box b of the same class.
   function automatic bit overlap_kills(input int unsigned a, input int unsigned b);
      longint il, it, ir, ib;
      logic signed [127:0] dx, dy, inter, area_a, area_b, uni, thr;
      il = (cand_box[a][0] > cand_box[b][0]) ? cand_box[a][0] : cand_box[b][0];
      it = (cand_box[a][1] > cand_box[b][1]) ? cand_box[a][1] : cand_box[b][1];
      ir = (cand_box[a][2] < cand_box[b][2]) ? cand_box[a][2] : cand_box[b][2];
      ib = (cand_box[a][3] < cand_box[b][3]) ? cand_box[a][3] : cand_box[b][3];
      if (il > ir || it > ib) return cfg_iou_thr == 0;
      dx = ir - il;
      dy = ib - it;
      inter = dx * dy;
      dx = longint'(cand_box[a][2]) - longint'(cand_box[a][0]);
      dy = longint'(cand_box[a][3]) - longint'(cand_box[a][1]);
      area_a = dx * dy;
      dx = longint'(cand_box[b][2]) - longint'(cand_box[b][0]);
      dy = longint'(cand_box[b][3]) - longint'(cand_box[b][1]);
      area_b = dx * dy;
      uni = area_a + area_b - inter;
      thr = longint'(cfg_iou_thr);
      if (uni == 0) return 1'b0;
      if (uni < 0) return inter == 0 && cfg_iou_thr == 0;
      return inter * 65536 >= uni * thr;
   endfunction

   task automatic suppress_frame(ref det_type outq[$]);
      int unsigned pick, i;
      int unsigned n;
      det_type d;
      n = cand_n;
      for (i = 0; i < n; i++) cand_live[i] = 1'b1;
      forever begin
         pick = n;
         for (i = 0; i < n; i++) begin
            if (!cand_live[i]) continue;
            if (pick == n || cand_cls[i] < cand_cls[pick] ||
                (cand_cls[i] == cand_cls[pick] && cand_score[i] > cand_score[pick]))
               pick = i;
         end
         if (pick == n) break;
         cand_live[pick] = 1'b0;
         for (i = 0; i < n; i++)
            if (cand_live[i] && cand_cls[i] == cand_cls[pick] && overlap_kills(pick, i))
               cand_live[i] = 1'b0;
         d = '0;
         d.left   = cand_box[pick][0];
         d.top    = cand_box[pick][1];
         d.right  = cand_box[pick][2];
         d.bottom = cand_box[pick][3];
         d.score  = cand_score[pick][16:0];
         d.cls    = cand_cls[pick][6:0];
         outq.insert(outq.size(), d);
      end
      if (outq.size() == 0) begin
         d = '0;
         d.empty_res = 1'b1;
         outq.insert(outq.size(), d);
      end
      outq[outq.size() - 1].last = 1'b1;
   endtask

   task automatic predict_value(input int v, input bit fl, ref det_type outq[$]);
      int unsigned p;
      p = row_pos;
      if (p < 4) row_box[p] = v;
      else if (p == 4) row_obj = v;
      else if (v > best_score) begin
         best_score = v;
         best_idx = p - dnms_pkg::ROW_HEAD;
      end
      if (p >= 4 + live_classes()) begin
         keep_row();
         clear_row();
      end else begin
         row_pos = p + 1;
      end
      if (fl) begin
         clear_row();
         suppress_frame(outq);
         cand_n = 0;
      end
   endtask

   task automatic send_value(input int v, input bit fl, input bit typed, input det_type want);
      int gap;
      det_type got_q[$];
      gap = req_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.value      <= v;
      req_ch.frame_last <= fl;
      do @(posedge clock); while (!req_ch.ready);
      predict_value(v, fl, got_q);
      if (typed) expected_dets.insert(expected_dets.size(), want);
      else foreach (got_q[i]) expected_dets.insert(expected_dets.size(), got_q[i]);
      items_sent++;
   endtask

   task automatic write_reg(input logic [3:0] idx, input int unsigned data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data[16:0];
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         dnms_pkg::REG_NUM_CLASSES: cfg_classes   = data & 32'hff;
         dnms_pkg::REG_SCORE_THR:   cfg_score_thr = data & 32'h1ffff;
         dnms_pkg::REG_IOU_THR:     cfg_iou_thr   = data & 32'h1ffff;
         dnms_pkg::REG_TOP_K:       cfg_top_k     = data & 32'h7f;
         default: ;
      endcase
   endtask

   task automatic set_config(input int unsigned nc, input int unsigned sthr,
                             input int unsigned ithr, input int unsigned k);
      write_reg(dnms_pkg::REG_NUM_CLASSES, nc);
      write_reg(dnms_pkg::REG_SCORE_THR, sthr);
      write_reg(dnms_pkg::REG_IOU_THR, ithr);
      write_reg(dnms_pkg::REG_TOP_K, k);
   endtask

   // Idle point: every expected box has arrived and the suppression pass is done.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_dets.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic int rand_field(input int base, input int spread);
      if ($urandom_range(0, 15) == 0) return int'($urandom);
      return base + int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // One frame of rows clustered so that boxes of a class overlap often.
   task automatic send_frame(input int rows);
      int cx0, cy0, prev;
      int vals[$];
      int unsigned nc;
      det_type none;
      none = '0;
      nc = live_classes();
      cx0 = int'($urandom_range(0, 32'h00400000)) - 32'h00200000;
      cy0 = int'($urandom_range(0, 32'h00400000)) - 32'h00200000;
      for (int r = 0; r < rows; r++) begin
         vals.insert(vals.size(), rand_field(cx0, 32'h8000));
         vals.insert(vals.size(), rand_field(cy0, 32'h8000));
         vals.insert(vals.size(), rand_field(32'h18000, 32'h10000));
         vals.insert(vals.size(), rand_field(32'h18000, 32'h10000));
         vals.insert(vals.size(), rand_field(32'hc000, 32'hc000));
         prev = 0;
         for (int c = 0; c < nc; c++) begin
            case ($urandom_range(0, 7))
               0: vals.insert(vals.size(), prev);
               1: vals.insert(vals.size(), -int'($urandom_range(0, 32'h10000)));
               default: vals.insert(vals.size(), rand_field(32'hc000, 32'hc000));
            endcase
            prev = vals[vals.size() - 1];
         end
      end
      // Now and then the frame ends inside a row, which drops that row.
      if ($urandom_range(0, 7) == 0 && vals.size() > 2)
         vals = vals[0:$urandom_range(0, vals.size() - 2)];
      foreach (vals[i]) send_value(vals[i], i == vals.size() - 1, 1'b0, none);
   endtask

   // Result side: random stalls, every transfer compared with the oldest expectation.
   initial begin
      int gap;
      det_type got, want;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = {rsp_ch.left, rsp_ch.top, rsp_ch.right, rsp_ch.bottom, rsp_ch.score,
                rsp_ch.cls_idx, rsp_ch.empty_res, rsp_ch.last};
         if (expected_dets.size() == 0) begin
            report($sformatf("unexpected result %s", det_text(got)));
         end else begin
            want = expected_dets.pop_front();
            if (got !== want)
               report($sformatf("got %s, want %s", det_text(got), det_text(want)));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_dets.size());
         $display("** detection_decode_class_nms_top: FAILED **");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_tab[$];
      det_type empty_det;
      int unsigned nc, sthr, ithr, k;
      int phase;
      errors = 0;
      items_sent = 0;
      cycles = 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      req_ch.frame_last <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      cfg_classes = dnms_pkg::NUM_CLASSES_RST;
      cfg_score_thr = dnms_pkg::SCORE_THR_RST;
      cfg_iou_thr = dnms_pkg::IOU_THR_RST;
      cfg_top_k = dnms_pkg::TOP_K_RST;
      clear_row();
      cand_n = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      empty_det = '0;
      empty_det.empty_res = 1'b1;
      empty_det.last = 1'b1;

      // Directed part at the reset register values: a lone value ends an empty frame.
      dir_tab.insert(dir_tab.size(), '{32'sh0, 1'b1, 1'b1, empty_det});
      foreach (dir_tab[i])
         send_value(dir_tab[i].value, dir_tab[i].frame_last, dir_tab[i].typed,
                    dir_tab[i].want);
      drain();
      dir_tab.delete();

      set_config(2, 16384, 29491, 64);
      // Strong box, class 1 wins over class 0.
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh20000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh20000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh8000,  1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      // Saturating edges and score, tie between classes keeps class 0.
      dir_tab.insert(dir_tab.size(), '{32'sh7fffffff, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh80000000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh7fffffff, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh80000000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh7fffffff, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh7fffffff, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh7fffffff, 1'b0, 1'b0, empty_det});
      // Objectness just below the threshold is dropped.
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh3fff,  1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh10000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh80000000, 1'b0, 1'b0, empty_det});
      // Partial row ended by the frame marker.
      dir_tab.insert(dir_tab.size(), '{32'sh18000, 1'b0, 1'b0, empty_det});
      dir_tab.insert(dir_tab.size(), '{32'sh18000, 1'b1, 1'b0, empty_det});
      foreach (dir_tab[i])
         send_value(dir_tab[i].value, dir_tab[i].frame_last, dir_tab[i].typed,
                    dir_tab[i].want);
      drain();

      // Random phases; the first few pin the register extremes.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase)
            0: begin nc = 3;   sthr = 16384; ithr = 29491;  k = 64;  end
            1: begin nc = 1;   sthr = 0;     ithr = 0;      k = 1;   end
            2: begin nc = 0;   sthr = 65536; ithr = 65536;  k = 127; end
            3: begin nc = 5;   sthr = 8192;  ithr = 131071; k = 0;   end
            4: begin nc = 128; sthr = 1000;  ithr = 32768;  k = 64;  end
            5: begin nc = 255; sthr = 20000; ithr = 1;      k = 2;   end
            6: begin nc = 2;   sthr = 0;     ithr = 16384;  k = 64;  end
            default: begin
               nc = $urandom_range(1, 6);
               sthr = $urandom_range(0, 4) == 0 ? $urandom_range(0, 131071)
                                                : $urandom_range(0, 32768);
               ithr = $urandom_range(0, 65536);
               k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                             : $urandom_range(1, 64);
            end
         endcase
         set_config(nc, sthr, ithr, k);
         for (int f = 0; f < ((nc >= 128) ? 1 : 3); f++) begin
            req_burst = $urandom_range(0, 3) == 0;
            rsp_burst = $urandom_range(0, 3) == 0;
            send_frame((nc >= 128) ? 2 : $urandom_range(1, 8));
         end
         drain();
         phase++;
      end

      req_burst = 1'b0;
      rsp_burst = 1'b0;
      drain();
      if (errors == 0) begin
         $display("** detection_decode_class_nms_top: PASSED **");
      end else begin
         $display("** detection_decode_class_nms_top: FAILED **");
      end
      $finish;
   end

endmodule
